// ----- rtl/core/etit_pkg.sv -----
// Shared types, codes and constants of the edge-triggered interval timer.
package etit_pkg;

  localparam int unsigned LimitW   = 29;
  localparam int unsigned SecW     = 19;
  localparam int unsigned NowW     = 32;
  localparam int unsigned SampleW  = 32;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // A trigger sample is high when strictly above this level (signed compare).
  localparam logic signed [SampleW-1:0] HighThreshold = 32'sd500;

  // ms -> s: shift out the factor 8, then multiply by ceil(2^33 / 125).
  localparam int unsigned DivPreShift = 3;
  localparam int unsigned DivInW      = LimitW - DivPreShift;
  localparam int unsigned DivMulW     = 27;
  localparam logic [DivMulW-1:0] DivMul = 27'd68719477;
  localparam int unsigned DivShift    = 33;
  localparam int unsigned DivProdW    = DivInW + DivMulW;
  localparam int unsigned DivQuotW    = DivProdW - DivShift;
  localparam logic [SecW-1:0] SecMax  = {SecW{1'b1}};

  typedef enum logic [ModeW-1:0] {
    MODE_TICK  = 3'd0,
    MODE_START = 3'd1,
    MODE_STOP  = 3'd2,
    MODE_RESET = 3'd3,
    MODE_ARM   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    EDGE_RISE  = 2'd0,
    EDGE_FALL  = 2'd1,
    EDGE_BOTH  = 2'd2,
    EDGE_LEVEL = 2'd3
  } edge_sel_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LIMIT_MS     = 3'd0,
    CFG_COUNT_DOWN   = 3'd1,
    CFG_START_EDGE   = 3'd2,
    CFG_STOP_EDGE    = 3'd3,
    CFG_START_ENABLE = 3'd4,
    CFG_STOP_ENABLE  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [ModeW-1:0]          mode;
    logic [NowW-1:0]           now_ms;
    logic signed [SampleW-1:0] start_sample;
    logic signed [SampleW-1:0] stop_sample;
  } in_item_t;

  typedef struct packed {
    logic [LimitW-1:0] elapsed_out;
    logic [SecW-1:0]   secs_out;
    logic              running_out;
    logic              expired_out;
    logic              status;
  } out_item_t;

  typedef struct packed {
    logic [LimitW-1:0] time_limit;
    logic              count_down;
    edge_sel_e         start_sel;
    edge_sel_e         stop_sel;
    logic              start_enable;
    logic              stop_enable;
  } cfg_t;

  typedef struct packed {
    logic [LimitW-1:0] elapsed;
    logic              running;
    logic              expired;
    logic              status;
  } core_res_t;

endpackage

// ----- rtl/core/etit_cfg_regs.sv -----
// Configuration register file of the interval timer.
module etit_cfg_regs
  import etit_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_limit   <= '0;
      cfg_q.count_down   <= 1'b0;
      cfg_q.start_sel    <= EDGE_RISE;
      cfg_q.stop_sel     <= EDGE_RISE;
      cfg_q.start_enable <= 1'b0;
      cfg_q.stop_enable  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LIMIT_MS:     cfg_q.time_limit   <= cfg_data_i[LimitW-1:0];
        CFG_COUNT_DOWN:   cfg_q.count_down   <= cfg_data_i[0];
        CFG_START_EDGE:   cfg_q.start_sel    <= edge_sel_e'(cfg_data_i[1:0]);
        CFG_STOP_EDGE:    cfg_q.stop_sel     <= edge_sel_e'(cfg_data_i[1:0]);
        CFG_START_ENABLE: cfg_q.start_enable <= cfg_data_i[0];
        CFG_STOP_ENABLE:  cfg_q.stop_enable  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/etit_core.sv -----
// Timer state and per-transaction update: triggers, commands, delta and expiry.
module etit_core
  import etit_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output core_res_t res_o
);

  logic              running_q, running_d;
  logic              expired_q, expired_d;
  logic [LimitW-1:0] elapsed_q, elapsed_d;
  logic [NowW-1:0]   start_time_q, start_time_d;
  logic              prev_start_q, prev_start_d;
  logic              prev_stop_q, prev_stop_d;
  logic              status_q, status_d;

  logic              start_lvl, stop_lvl;
  logic              tick_start_hit;
  logic [NowW-1:0]   start_ref;
  logic [NowW-1:0]   delta;
  logic              delta_expired;
  logic [LimitW-1:0] begin_elapsed;

  function automatic logic trigger_hit(logic prev, logic curr, edge_sel_e sel);
    logic hit;
    case (sel)
      EDGE_RISE:  hit = !prev && curr;
      EDGE_FALL:  hit = prev && !curr;
      EDGE_BOTH:  hit = prev != curr;
      EDGE_LEVEL: hit = curr;
      default:    hit = curr;
    endcase
    return hit;
  endfunction

  assign start_lvl = item_i.start_sample > HighThreshold;
  assign stop_lvl  = item_i.stop_sample > HighThreshold;

  assign tick_start_hit = !running_q && cfg_i.start_enable
                          && trigger_hit(prev_start_q, start_lvl, cfg_i.start_sel);

  // A start on this tick measures from now, so delta is zero.
  assign start_ref     = tick_start_hit ? item_i.now_ms : start_time_q;
  assign delta         = item_i.now_ms - start_ref;
  assign delta_expired = delta >= NowW'(cfg_i.time_limit);
  assign begin_elapsed = cfg_i.count_down ? cfg_i.time_limit : '0;

  always_comb begin
    running_d    = running_q;
    expired_d    = expired_q;
    elapsed_d    = elapsed_q;
    start_time_d = start_time_q;
    prev_start_d = prev_start_q;
    prev_stop_d  = prev_stop_q;
    status_d     = 1'b0;

    case (item_i.mode)
      MODE_TICK: begin
        if (!running_q && cfg_i.start_enable) begin
          prev_start_d = start_lvl;
        end
        if (running_q || tick_start_hit) begin
          start_time_d = start_ref;
          if (delta_expired) begin
            elapsed_d = cfg_i.count_down ? '0 : cfg_i.time_limit;
            expired_d = 1'b1;
            running_d = 1'b0;
          end else begin
            elapsed_d = cfg_i.count_down ? cfg_i.time_limit - delta[LimitW-1:0]
                                         : delta[LimitW-1:0];
            expired_d = tick_start_hit ? 1'b0 : expired_q;
            running_d = 1'b1;
            if (cfg_i.stop_enable) begin
              if (trigger_hit(prev_stop_q, stop_lvl, cfg_i.stop_sel)) begin
                running_d = 1'b0;
              end
              prev_stop_d = stop_lvl;
            end
          end
        end
      end
      MODE_START: begin
        if (running_q) begin
          status_d = 1'b1;
        end else begin
          running_d    = 1'b1;
          expired_d    = 1'b0;
          start_time_d = item_i.now_ms;
          elapsed_d    = begin_elapsed;
        end
      end
      MODE_STOP: begin
        if (!running_q) begin
          status_d = 1'b1;
        end else begin
          running_d = 1'b0;
        end
      end
      MODE_RESET: begin
        running_d    = 1'b0;
        expired_d    = 1'b0;
        elapsed_d    = '0;
        start_time_d = '0;
      end
      MODE_ARM: begin
        running_d    = 1'b0;
        expired_d    = 1'b0;
        elapsed_d    = '0;
        start_time_d = '0;
        if (cfg_i.start_enable) begin
          prev_start_d = start_lvl;
        end
        if (cfg_i.stop_enable) begin
          prev_stop_d = stop_lvl;
        end
      end
      default: begin
        status_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= 1'b0;
      expired_q    <= 1'b0;
      elapsed_q    <= '0;
      start_time_q <= '0;
      prev_start_q <= 1'b0;
      prev_stop_q  <= 1'b0;
      status_q     <= 1'b0;
    end else if (adv_i) begin
      running_q    <= running_d;
      expired_q    <= expired_d;
      elapsed_q    <= elapsed_d;
      start_time_q <= start_time_d;
      prev_start_q <= prev_start_d;
      prev_stop_q  <= prev_stop_d;
      status_q     <= status_d;
    end
  end

  assign res_o.elapsed = elapsed_q;
  assign res_o.running = running_q;
  assign res_o.expired = expired_q;
  assign res_o.status  = status_q;

endmodule

// ----- rtl/core/etit_out_stage.sv -----
// Result register: whole-second conversion and output transaction payload.
module etit_out_stage
  import etit_pkg::*;
(
  input  logic      clk_i,
  input  logic      load_i,
  input  core_res_t res_i,
  output out_item_t item_o
);

  logic [DivInW-1:0]   div_in;
  logic [DivProdW-1:0] div_prod;
  logic [DivQuotW-1:0] quot;
  logic [SecW-1:0]     secs;
  out_item_t           item_q;

  // x / 1000 == (x / 8) / 125; the reciprocal is exact over the 26-bit range.
  assign div_in   = res_i.elapsed[LimitW-1:DivPreShift];
  assign div_prod = DivProdW'(div_in) * DivProdW'(DivMul);
  assign quot     = div_prod[DivProdW-1:DivShift];

  // Saturate where the quotient leaves the seconds field.
  assign secs = (quot > DivQuotW'(SecMax)) ? SecMax : quot[SecW-1:0];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q.elapsed_out <= res_i.elapsed;
      item_q.secs_out    <= secs;
      item_q.running_out <= res_i.running;
      item_q.expired_out <= res_i.expired;
      item_q.status      <= res_i.status;
    end
  end

  assign item_o = item_q;

endmodule

// ----- rtl/core/edge_triggered_interval_timer_core.sv -----
// A result is valid once its transaction has passed the input register, the state update
// register and the result register. Throughput: one transaction per cycle while the output
// is not stalled; each of these stages advances whenever the next one drains.
// The seconds multiplier sits between the state update and result registers.
// Reset: asynchronous, active low; clears valid flags, timer state and config.
// Timer state is usable in the first cycle after reset is released.
module edge_triggered_interval_timer_core
  import etit_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg;
  core_res_t core_res;

  logic     a_valid_q, b_valid_q, c_valid_q;
  in_item_t a_item_q;
  logic     in_fire, a_adv, b_adv, b_free, c_free;

  assign c_free  = !c_valid_q || out_ready_i;
  assign b_free  = !b_valid_q || c_free;
  assign b_adv   = b_valid_q && c_free;
  assign a_adv   = a_valid_q && b_free;

  assign in_ready_o = !a_valid_q || b_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= in_fire || (a_valid_q && !b_free);
      b_valid_q <= a_adv || (b_valid_q && !c_free);
      c_valid_q <= b_adv || (c_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_item_q <= in_item_i;
    end
  end

  etit_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  etit_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (a_adv),
    .item_i (a_item_q),
    .cfg_i  (cfg),
    .res_o  (core_res)
  );

  etit_out_stage u_out_stage (
    .clk_i  (clk_i),
    .load_i (b_adv),
    .res_i  (core_res),
    .item_o (out_item_o)
  );

  assign out_valid_o = c_valid_q;

endmodule

// ----- rtl/core/etit_checker.sv -----
// Port-level checks of the interval timer, bound to the top level.
module etit_checker
  import etit_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // Hold a stalled result transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result transaction dropped or changed while stalled");

  // Drop all results while in reset.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // Running and expired exclude each other.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.running_out && out_item_o.expired_out))
    else $error("timer shows running and expired at once");

  // Seconds agree with milliseconds unless saturated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.secs_out != SecMax) |->
      (32'(out_item_o.secs_out) * 32'd1000 <= 32'(out_item_o.elapsed_out)) &&
      (32'(out_item_o.elapsed_out) < 32'(out_item_o.secs_out) * 32'd1000 + 32'd1000))
    else $error("seconds field disagrees with milliseconds");

endmodule

bind edge_triggered_interval_timer_core etit_checker u_etit_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for the edge-triggered interval timer core.
`timescale 1ns / 100ps

module testbench;
  import etit_pkg::*;

  localparam int unsigned CycleLimit    = 600000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned PhaseCount    = 9;
  localparam int unsigned ItemsPerPhase = 120;
  localparam int unsigned HoldPhase     = 3;
  localparam int unsigned QuietPhase    = 5;
  localparam int unsigned MsPerSecond   = 1000;
  localparam int unsigned HighLevel     = HighThreshold;
  localparam int unsigned ReportLimit   = 10;

  localparam logic [ModeW-1:0]   ModeFirstUnused = 3'd5;
  localparam logic [ModeW-1:0]   ModeLastUnused  = 3'd7;
  localparam logic [CfgIdxW-1:0] CfgFirstUnused  = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgLastUnused   = 3'd7;

  class timer_scoreboard;
    logic [LimitW-1:0] limit;
    bit                count_down;
    edge_sel_e         start_sel;
    edge_sel_e         stop_sel;
    bit                start_en;
    bit                stop_en;
    bit                running;
    bit                expired;
    logic [LimitW-1:0] elapsed;
    logic [NowW-1:0]   start_time;
    bit                prev_start_hi;
    bit                prev_stop_hi;
    out_item_t         readout_q[$];
    int unsigned       mismatches;
    int unsigned       checked;

    function new();
      limit         = '0;
      count_down    = 1'b0;
      start_sel     = EDGE_RISE;
      stop_sel      = EDGE_RISE;
      start_en      = 1'b0;
      stop_en       = 1'b0;
      running       = 1'b0;
      expired       = 1'b0;
      elapsed       = '0;
      start_time    = '0;
      prev_start_hi = 1'b0;
      prev_stop_hi  = 1'b0;
      mismatches    = 0;
      checked       = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_LIMIT_MS:     limit = data[LimitW-1:0];
        CFG_COUNT_DOWN:   count_down = data[0];
        CFG_START_EDGE:   start_sel = edge_sel_e'(data[1:0]);
        CFG_STOP_EDGE:    stop_sel = edge_sel_e'(data[1:0]);
        CFG_START_ENABLE: start_en = data[0];
        CFG_STOP_ENABLE:  stop_en = data[0];
        default: ;
      endcase
    endfunction

    function bit level_high(logic signed [SampleW-1:0] s);
      return s > HighThreshold;
    endfunction

    function bit trigger_hit(bit prev, bit cur, edge_sel_e sel);
      case (sel)
        EDGE_RISE: return !prev && cur;
        EDGE_FALL: return prev && !cur;
        EDGE_BOTH: return prev != cur;
        default:   return cur;
      endcase
    endfunction

    function void launch(logic [NowW-1:0] now);
      running    = 1'b1;
      expired    = 1'b0;
      start_time = now;
      elapsed    = count_down ? limit : '0;
    endfunction

    function void clear_timer();
      running    = 1'b0;
      expired    = 1'b0;
      elapsed    = '0;
      start_time = '0;
    endfunction

    function void tick(logic [NowW-1:0] now, bit start_lvl, bit stop_lvl);
      logic [NowW-1:0] delta;
      if (!running && start_en) begin
        if (trigger_hit(prev_start_hi, start_lvl, start_sel)) launch(now);
        prev_start_hi = start_lvl;
      end
      if (running) begin
        // modular delta handles the wrap of the millisecond counter
        delta = now - start_time;
        if (delta >= NowW'(limit)) begin
          elapsed = count_down ? '0 : limit;
          expired = 1'b1;
          running = 1'b0;
        end else begin
          elapsed = count_down ? limit - delta[LimitW-1:0] : delta[LimitW-1:0];
        end
        if (running && stop_en) begin
          if (trigger_hit(prev_stop_hi, stop_lvl, stop_sel)) running = 1'b0;
          prev_stop_hi = stop_lvl;
        end
      end
    endfunction

    function void note_item(in_item_t it);
      bit          start_lvl;
      bit          stop_lvl;
      bit          rejected;
      int unsigned secs;
      out_item_t   r;
      start_lvl = level_high(it.start_sample);
      stop_lvl  = level_high(it.stop_sample);
      rejected  = 1'b0;
      case (it.mode)
        MODE_TICK:  tick(it.now_ms, start_lvl, stop_lvl);
        MODE_START: begin
          if (running) rejected = 1'b1;
          else launch(it.now_ms);
        end
        MODE_STOP: begin
          if (!running) rejected = 1'b1;
          else running = 1'b0;
        end
        MODE_RESET: clear_timer();
        MODE_ARM: begin
          clear_timer();
          if (start_en) prev_start_hi = start_lvl;
          if (stop_en) prev_stop_hi = stop_lvl;
        end
        default: rejected = 1'b1;
      endcase
      secs = 32'(elapsed) / MsPerSecond;
      if (secs > SecMax) secs = 32'(SecMax);
      r.elapsed_out = elapsed;
      r.secs_out    = secs[SecW-1:0];
      r.running_out = running;
      r.expired_out = expired;
      r.status      = rejected;
      readout_q.push_back(r);
    endfunction

    function void check_readout(out_item_t got);
      out_item_t want;
      bit        bad;
      if (readout_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected readout: elapsed %0d secs %0d run %0b exp %0b status %0b",
                   got.elapsed_out, got.secs_out, got.running_out,
                   got.expired_out, got.status);
        return;
      end
      want = readout_q.pop_front();
      checked++;
      bad = (got.elapsed_out !== want.elapsed_out) ||
            (got.secs_out !== want.secs_out) ||
            (got.running_out !== want.running_out) ||
            (got.expired_out !== want.expired_out) ||
            (got.status !== want.status);
      if (bad) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("readout %0d differs, expected: elapsed %0d secs %0d run %0b exp %0b st %0b",
                   checked, want.elapsed_out, want.secs_out, want.running_out,
                   want.expired_out, want.status);
          $display("readout %0d differs, actual:   elapsed %0d secs %0d run %0b exp %0b st %0b",
                   checked, got.elapsed_out, got.secs_out, got.running_out,
                   got.expired_out, got.status);
        end
      end
    endfunction

    function int unsigned pending();
      return readout_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  in_item_t            in_item = '0;
  logic                out_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_ready;
  logic                out_valid;
  out_item_t           out_item;
  logic                cfg_ready;

  timer_scoreboard sb;
  int unsigned     cycle_count = 0;
  int unsigned     items_sent = 0;
  bit              no_idle = 1'b0;
  bit              hold_req = 1'b0;

  edge_triggered_interval_timer_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Observe every transaction on all three channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_item(in_item);
      if (out_valid && out_ready) sb.check_readout(out_item);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SampleW-1:0] pick_sample(bit want_high);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (want_high) begin
      if (r == 0) return HighThreshold + 1;
      if (r == 1) return 32'sh7fffffff;
      return $urandom_range(32'h7fffffff, HighLevel + 1);
    end
    if (r == 0) return HighThreshold;
    if (r == 1) return 32'sh80000000;
    if (r < 5) return $urandom_range(HighLevel, 0);
    return $urandom | 32'h80000000;
  endfunction

  task automatic send_item(in_item_t it, int unsigned gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic offer(logic [ModeW-1:0] mode, logic [NowW-1:0] now,
                       logic signed [SampleW-1:0] ss, logic signed [SampleW-1:0] sp);
    in_item_t it;
    it.mode         = mode;
    it.now_ms       = now;
    it.start_sample = ss;
    it.stop_sample  = sp;
    send_item(it, pick_gap());
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic cfg_done();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop the input and wait for every outstanding readout before reconfiguring.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_directed();
    cfg_write(CFG_LIMIT_MS, 32'd5000);
    cfg_write(CFG_COUNT_DOWN, 32'd0);
    cfg_write(CFG_START_EDGE, 32'(EDGE_RISE));
    cfg_write(CFG_STOP_EDGE, 32'(EDGE_FALL));
    cfg_write(CFG_START_ENABLE, 32'd1);
    cfg_write(CFG_STOP_ENABLE, 32'd1);
    cfg_write(CfgFirstUnused, $urandom);
    cfg_write(CfgLastUnused, $urandom);
    cfg_done();
    offer(MODE_ARM, 32'd100, 32'sd0, 32'sd0);
    offer(MODE_TICK, 32'd200, 32'sd501, 32'sd0);
    offer(MODE_TICK, 32'd1700, 32'sd500, 32'sh7fffffff);
    offer(MODE_TICK, 32'd2700, 32'sd0, -32'sd1);
    offer(MODE_STOP, 32'd0, 32'sd0, 32'sd0);
    offer(MODE_START, 32'hFFFFF000, 32'sd0, 32'sd0);
    offer(MODE_START, 32'hFFFFF800, 32'sd0, 32'sd0);
    // counter wraps between start and this tick
    offer(MODE_TICK, 32'h00000100, 32'sh80000000, 32'sd0);
    offer(MODE_TICK, 32'h00000400, 32'sh80000000, 32'sd0);
    offer(MODE_TICK, 32'hFFFFFFFF, 32'sh80000000, 32'sh80000000);
    offer(MODE_STOP, 32'd0, 32'sd0, 32'sd0);
    offer(MODE_RESET, 32'hFFFFFFFF, 32'sh7fffffff, 32'sh7fffffff);
    for (int m = ModeFirstUnused; m <= ModeLastUnused; m++)
      offer(ModeW'(m), $urandom, $urandom, $urandom);
    offer(MODE_ARM, 32'd0, 32'sd600, 32'sd700);
    offer(MODE_TICK, 32'd10, 32'sd600, 32'sd700);
    drain();
    // zero limit: every running tick expires at once
    cfg_write(CFG_LIMIT_MS, 32'hE0000000);
    cfg_write(CFG_COUNT_DOWN, 32'd1);
    cfg_write(CFG_START_EDGE, 32'(EDGE_LEVEL));
    cfg_write(CFG_STOP_EDGE, 32'(EDGE_LEVEL));
    cfg_done();
    offer(MODE_TICK, 32'd0, 32'sd501, 32'sd0);
    offer(MODE_START, 32'd5, 32'sd0, 32'sd0);
    offer(MODE_TICK, 32'd5, 32'sd0, 32'sd0);
    drain();
    // widest limit: seconds readout saturates
    cfg_write(CFG_LIMIT_MS, 32'hFFFFFFFF);
    cfg_write(CFG_COUNT_DOWN, 32'd0);
    cfg_write(CFG_START_EDGE, 32'(EDGE_BOTH));
    cfg_write(CFG_STOP_EDGE, 32'(EDGE_BOTH));
    cfg_done();
    offer(MODE_ARM, 32'd0, 32'sd0, 32'sd0);
    offer(MODE_TICK, 32'hFFFFFFFF, 32'sd2000, 32'sd0);
    offer(MODE_TICK, 32'h1FFF0000, 32'sd2000, 32'sd0);
    offer(MODE_STOP, 32'h1FFF0001, 32'sd0, 32'sd0);
    drain();
  endtask

  task automatic setup_phase(int unsigned p);
    logic [CfgDataW-1:0] lim;
    int unsigned         r;
    r = $urandom_range(0, 9);
    if (p == 0) lim = $urandom & 32'hE0000000;
    else if (p == 1) lim = 32'hFFFFFFFF;
    else if (r < 3) lim = $urandom_range(0, 40) | ($urandom & 32'hE0000000);
    else if (r < 8) lim = $urandom_range(100, 30000) | ($urandom & 32'hE0000000);
    else lim = $urandom;
    cfg_write(CFG_LIMIT_MS, lim);
    cfg_write(CFG_COUNT_DOWN, ($urandom & ~32'd1) | 32'(p % 2));
    cfg_write(CFG_START_EDGE, ($urandom & ~32'd3) | 32'(p % 4));
    cfg_write(CFG_STOP_EDGE, ($urandom & ~32'd3) | 32'((p + 2 + p / 4) % 4));
    cfg_write(CFG_START_ENABLE, ($urandom & ~32'd1) | 32'(p % 5 != 3));
    cfg_write(CFG_STOP_ENABLE, ($urandom & ~32'd1) | 32'(p % 5 != 1));
    if (p % 3 == 0)
      cfg_write(CfgIdxW'($urandom_range(CfgLastUnused, CfgFirstUnused)), $urandom);
    cfg_done();
  endtask

  task automatic run_random(int unsigned p, int unsigned count);
    logic [NowW-1:0] clock_ms;
    int unsigned     step_max;
    int unsigned     r;
    bit              start_lvl;
    bit              stop_lvl;
    in_item_t        it;
    clock_ms  = $urandom;
    start_lvl = 1'b0;
    stop_lvl  = 1'b0;
    step_max  = 32'(sb.limit) / 3 + 1;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 62) it.mode = MODE_TICK;
      else if (r < 70) it.mode = MODE_START;
      else if (r < 77) it.mode = MODE_STOP;
      else if (r < 81) it.mode = MODE_RESET;
      else if (r < 90) it.mode = MODE_ARM;
      else if (r < 94) it.mode = ModeW'($urandom_range(ModeLastUnused, ModeFirstUnused));
      else it.mode = MODE_TICK;
      // advance time in steps of up to a third of the limit, with an occasional jump
      if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, step_max);
      it.now_ms = clock_ms;
      if ($urandom_range(0, 2) == 0) start_lvl = !start_lvl;
      if ($urandom_range(0, 2) == 0) stop_lvl = !stop_lvl;
      if ($urandom_range(0, 9) == 0) begin
        it.start_sample = $urandom;
        it.stop_sample  = $urandom;
      end else begin
        it.start_sample = pick_sample(start_lvl);
        it.stop_sample  = pick_sample(stop_lvl);
      end
      send_item(it, pick_gap());
      if (p == HoldPhase && i == 20) hold_req = 1'b1;
    end
  endtask

  initial begin : receiver
    int unsigned gap;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (int unsigned n = 0; n < HoldCycles; n++) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (gap) @(negedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) @(posedge clk);
    $display("timeout after %0d cycles", cycle_count);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int unsigned p = 0; p < PhaseCount; p++) begin
      no_idle = (p == QuietPhase);
      setup_phase(p);
      run_random(p, ItemsPerPhase);
      drain();
    end
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d input transactions, %0d readouts checked, %0d random settings",
             items_sent, sb.checked, PhaseCount);
    $display("plus directed corners: wrap, zero and widest limit, rejected and unknown commands");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d readouts missing", sb.mismatches, sb.pending());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
